FILE: rtl/hdpm_pkg.sv
// Shared types, constants and character helpers for the destination parser and matcher.
package hdpm_pkg;

	localparam int TABLE_DEPTH_DEF   = 32;
	localparam int MAX_FIELDS_DEF    = 8;
	localparam int MAX_FIELD_LEN_DEF = 8;

	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NOAT = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] character;
		logic       end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        matched;
		logic [3:0]  field_total;
		logic [15:0] check_word;
	} out_beat_t;

	function automatic logic is_word(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
		       (c >= 8'h61 && c <= 8'h7a) || (c == CH_STAR);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

endpackage

FILE: rtl/hier_dest_parse_match.sv
// Top level of the hierarchical destination parser and matcher.
// Usage: drive one character beat on cmd with start high; it is taken at an
// edge where busy is low. Beats of a string arrive one per cycle while idle.
// Operation clear empties the table at once and gives no result.
// A string's last beat (end_of_string) yields one result: strobe is high for
// exactly one cycle, in the cycle after the last beat or after the table walk.
// Error strings, stores and trivial queries report in the cycle after the
// last beat. A store then copies the query buffer into the table through the
// copy and flush states with busy high.
// A query with fields walks the table on the shared compare datapath: per
// entry a header read (ERD) and check (ECHK), then per compared character or
// empty query field a read (FRD) and a compare (FCHK); one registered read of
// each memory per compare step.
// The receiver cannot stall: results are shown once and never held.
// Reset clears the parser, entry count and sequencer; the memories hold
// garbage until written; a store also copies unwritten query buffer bytes, but only written characters are compared.
module hier_dest_parse_match
	import hdpm_pkg::*;
#(
	parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
	parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
	parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_beat_t  cmd,
	output logic      strobe,
	output out_beat_t result
);

	localparam int FW   = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CFW  = $clog2(MAX_FIELDS + 1);
	localparam int CW   = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
	localparam int LW   = $clog2(MAX_FIELD_LEN + 1);
	localparam int EW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ECW  = $clog2(TABLE_DEPTH + 1);
	localparam int QD   = MAX_FIELDS * MAX_FIELD_LEN;
	localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
	localparam int LD   = TABLE_DEPTH * MAX_FIELDS;
	localparam int LAW  = (LD > 1) ? $clog2(LD) : 1;
	localparam int TD   = TABLE_DEPTH * QD;
	localparam int TAW  = (TD > 1) ? $clog2(TD) : 1;

	localparam logic [2:0] PH_SKIP  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_FIELD = 3'd2;
	localparam logic [2:0] PH_DONE  = 3'd3;
	localparam logic [2:0] PH_NOAT  = 3'd4;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COPY  = 3'd1;
	localparam logic [2:0] S_FLUSH = 3'd2;
	localparam logic [2:0] S_ERD   = 3'd3;
	localparam logic [2:0] S_ECHK  = 3'd4;
	localparam logic [2:0] S_FRD   = 3'd5;
	localparam logic [2:0] S_FCHK  = 3'd6;

	// memories
	logic [7:0]     qmem     [QD];
	logic [7:0]     tchar_mem[TD];
	logic [LW-1:0]  tlen_mem [LD];
	logic [CFW-1:0] cnt_mem  [TABLE_DEPTH];

	logic [7:0]     qch_rd_q, tch_rd_q;
	logic [LW-1:0]  tlen_rd_q;
	logic [CFW-1:0] cnt_rd_q;

	// parser state
	logic [2:0]     ph_q, ph_d;
	logic [CFW-1:0] cf_q, cf_d;
	logic           ovf_q, ovf_d;
	logic [15:0]    sum_q, sum_d;
	logic [LW-1:0]  qlen_q[MAX_FIELDS];
	logic [LW-1:0]  qlen_d[MAX_FIELDS];
	logic [7:0]     first_q, first_d;
	logic [ECW-1:0] ec_q;

	// sequencer state
	logic [2:0]     state_q;
	logic [CFW-1:0] qn_q;
	logic [EW-1:0]  e_q;
	logic [FW-1:0]  qf_q, tf_q, cpf_q;
	logic [CW-1:0]  ci_q, cpc_q;
	logic           cpv_s1;
	logic [TAW-1:0] cpa_s1;
	out_beat_t      res_q;
	logic           strobe_q;

	logic           take, op_ok, wc, open_req, add_req;
	logic [7:0]     uc;
	logic           qwe;
	logic [QAW-1:0] qwaddr, qraddr;
	logic [FW-1:0]  cur_f;
	logic [LW-1:0]  cur_len;
	logic [15:0]    check_d;
	logic [TAW-1:0] taddr, cp_taddr;
	logic [LAW-1:0] laddr, cp_laddr;
	logic [LW-1:0]  lenq;

	assign take  = start && !busy;
	assign op_ok = take && (cmd.operation == OP_QUERY || cmd.operation == OP_STORE);
	assign wc    = is_word(cmd.character);
	assign uc    = to_upper(cmd.character);
	assign busy  = (state_q != S_IDLE);

	// parse one character: advance phase, open fields, append characters
	always_comb begin
		ph_d     = ph_q;
		cf_d     = cf_q;
		ovf_d    = ovf_q;
		sum_d    = sum_q;
		qlen_d   = qlen_q;
		first_d  = first_q;
		open_req = 1'b0;
		add_req  = 1'b0;
		qwe      = 1'b0;
		cur_f    = '0;
		cur_len  = '0;
		case (ph_q)
			PH_SKIP: begin
				if (cmd.character == CH_AT)
					ph_d = PH_START;
				else if (cmd.character != CH_SPACE && cmd.character != CH_COMMA)
					ph_d = PH_NOAT;
			end
			PH_START: begin
				if (cmd.character == CH_DOT || wc) begin
					open_req = 1'b1;
					add_req  = wc;
					ph_d     = PH_FIELD;
				end else begin
					ph_d = PH_DONE;
				end
			end
			PH_FIELD: begin
				if (wc)
					add_req = 1'b1;
				else if (cmd.character == CH_DOT)
					open_req = 1'b1;
				else
					ph_d = PH_DONE;
			end
			default: ;
		endcase
		if (open_req && !ovf_q) begin
			if (int'(cf_q) < MAX_FIELDS) begin
				qlen_d[cf_q[FW-1:0]] = '0;
				cf_d = cf_q + CFW'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
		if (add_req) begin
			sum_d = sum_q + {8'd0, uc};
			if (!ovf_d && cf_d != '0) begin
				cur_f   = FW'(cf_d - CFW'(1));
				cur_len = qlen_d[cur_f];
				if (int'(cur_len) < MAX_FIELD_LEN) begin
					qwe = 1'b1;
					qlen_d[cur_f] = cur_len + LW'(1);
					if (cur_f == '0 && cur_len == '0)
						first_d = uc;
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	assign qwaddr  = QAW'(int'(cur_f) * MAX_FIELD_LEN + int'(cur_len));
	assign check_d = {sum_d[11:0], 4'd0} + {12'd0, 4'(cf_d)};

	// shared address datapath: copy uses cp counters, walk uses compare counters
	assign qraddr   = (state_q == S_COPY) ?
	                  QAW'(int'(cpf_q) * MAX_FIELD_LEN + int'(cpc_q)) :
	                  QAW'(int'(qf_q) * MAX_FIELD_LEN + int'(ci_q));
	assign taddr    = TAW'((int'(e_q) * MAX_FIELDS + int'(tf_q)) * MAX_FIELD_LEN + int'(ci_q));
	assign laddr    = LAW'(int'(e_q) * MAX_FIELDS + int'(tf_q));
	assign cp_taddr = TAW'((int'(ec_q) * MAX_FIELDS + int'(cpf_q)) * MAX_FIELD_LEN
	                  + int'(cpc_q));
	assign cp_laddr = LAW'(int'(ec_q) * MAX_FIELDS + int'(cpf_q));
	assign lenq     = qlen_q[qf_q];

	// memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (op_ok && qwe)
			qmem[qwaddr] <= uc;
		qch_rd_q <= qmem[qraddr];
		if (cpv_s1)
			tchar_mem[cpa_s1] <= qch_rd_q;
		tch_rd_q <= tchar_mem[taddr];
		if (state_q == S_COPY && cpc_q == '0)
			tlen_mem[cp_laddr] <= qlen_q[cpf_q];
		tlen_rd_q <= tlen_mem[laddr];
		if (state_q == S_COPY && cpc_q == '0 && cpf_q == '0)
			cnt_mem[ec_q[EW-1:0]] <= qn_q;
		cnt_rd_q <= cnt_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (op_ok)
			first_q <= first_d;
		cpa_s1  <= cp_taddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_SKIP;
			cf_q     <= '0;
			ovf_q    <= 1'b0;
			sum_q    <= '0;
			for (int i = 0; i < MAX_FIELDS; i++)
				qlen_q[i] <= '0;
			ec_q     <= '0;
			state_q  <= S_IDLE;
			qn_q     <= '0;
			e_q      <= '0;
			qf_q     <= '0;
			tf_q     <= '0;
			ci_q     <= '0;
			cpf_q    <= '0;
			cpc_q    <= '0;
			cpv_s1   <= 1'b0;
			res_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			cpv_s1   <= (state_q == S_COPY);
			if (op_ok) begin
				ph_q   <= ph_d;
				cf_q   <= cf_d;
				ovf_q  <= ovf_d;
				sum_q  <= sum_d;
				qlen_q <= qlen_d;
			end
			if (take && cmd.operation == OP_CLEAR)
				ec_q <= '0;
			if (op_ok && cmd.end_of_string) begin
				// string done: drop parser state, decide result, start a walk or a copy
				ph_q  <= PH_SKIP;
				cf_q  <= '0;
				ovf_q <= 1'b0;
				sum_q <= '0;
				qn_q  <= cf_d;
				res_q.status      <= ST_OK;
				res_q.matched     <= 1'b0;
				res_q.field_total <= 4'(cf_d);
				res_q.check_word  <= check_d;
				if (ph_d == PH_SKIP || ph_d == PH_NOAT) begin
					res_q.status      <= ST_NOAT;
					res_q.field_total <= '0;
					res_q.check_word  <= '0;
					strobe_q          <= 1'b1;
				end else if (ovf_d) begin
					res_q.status <= ST_LONG;
					strobe_q     <= 1'b1;
				end else if (cmd.operation == OP_QUERY) begin
					if (ec_q == '0) begin
						strobe_q <= 1'b1;
					end else if ((cf_d == CFW'(1) && qlen_d[0] == LW'(1) &&
					              first_d == CH_STAR) || cf_d == '0) begin
						res_q.matched <= 1'b1;
						strobe_q      <= 1'b1;
					end else begin
						e_q     <= '0;
						state_q <= S_ERD;
					end
				end else if (int'(ec_q) >= TABLE_DEPTH) begin
					res_q.status <= ST_FULL;
					strobe_q     <= 1'b1;
				end else begin
					strobe_q <= 1'b1;
					cpf_q    <= '0;
					cpc_q    <= '0;
					state_q  <= S_COPY;
				end
			end
			case (state_q)
				S_COPY: begin
					if (int'(cpc_q) == MAX_FIELD_LEN - 1) begin
						cpc_q <= '0;
						if (int'(cpf_q) == MAX_FIELDS - 1)
							state_q <= S_FLUSH;
						else
							cpf_q <= cpf_q + FW'(1);
					end else begin
						cpc_q <= cpc_q + CW'(1);
					end
				end
				S_FLUSH: begin
					ec_q    <= ec_q + ECW'(1);
					state_q <= S_IDLE;
				end
				S_ERD: state_q <= S_ECHK;
				S_ECHK: begin
					if (qn_q <= cnt_rd_q) begin
						tf_q    <= FW'(cnt_rd_q - qn_q);
						qf_q    <= '0;
						ci_q    <= '0;
						state_q <= S_FRD;
					end else if (ECW'(e_q) + ECW'(1) < ec_q) begin
						e_q     <= e_q + EW'(1);
						state_q <= S_ERD;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (tlen_rd_q != lenq || (lenq != '0 && tch_rd_q != qch_rd_q)) begin
						// mismatch: advance to next entry or give up
						if (ECW'(e_q) + ECW'(1) < ec_q) begin
							e_q     <= e_q + EW'(1);
							state_q <= S_ERD;
						end else begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (LW'(ci_q) + LW'(1) < lenq) begin
						ci_q    <= ci_q + CW'(1);
						state_q <= S_FRD;
					end else if (CFW'(qf_q) + CFW'(1) == qn_q) begin
						res_q.matched <= 1'b1;
						strobe_q      <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						qf_q    <= qf_q + FW'(1);
						tf_q    <= tf_q + FW'(1);
						ci_q    <= '0;
						state_q <= S_FRD;
					end
				end
				default: ;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

FILE: rtl/hdpm_checker.sv
// Port-level checker for the destination parser and matcher, with its bind.
module hdpm_checker
	import hdpm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_beat_t  cmd,
	input logic      strobe,
	input out_beat_t result
);

	a_noat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == ST_NOAT |->
			result.field_total == '0 && result.check_word == '0 && !result.matched)
		else $error("no at-sign result carries data");

	a_err_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> !result.matched)
		else $error("error result reports a match");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.operation == OP_CLEAR |=> !busy && !strobe)
		else $error("clear started work or gave a result");

	a_mid_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cmd.end_of_string |=> !strobe)
		else $error("result after a mid-string beat");

endmodule

bind hier_dest_parse_match hdpm_checker u_hdpm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.strobe (strobe),
	.result (result)
);

FILE: verif/hier_dest_parse_match_test.sv
// Self-checking testbench for the hierarchical destination parser and matcher.
module hier_dest_parse_match_test;
	import hdpm_pkg::*;

	localparam int NUM_ITEMS   = 1500;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 20;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum logic [2:0] {PS_SKIP, PS_START, PS_FIELD, PS_DONE, PS_NOAT} parse_state_t;

	typedef struct {
		in_beat_t beat;
		int       gap;
		bit       drain;
	} pend_beat_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_beat_t  cmd;
	logic      strobe;
	out_beat_t result;

	hier_dest_parse_match u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	// Free-running clock, period 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the destination table and the parser.
	// ------------------------------------------------------------------
	logic [7:0]   tbl_chars [TABLE_DEPTH_DEF][MAX_FIELDS_DEF][MAX_FIELD_LEN_DEF];
	int           tbl_len   [TABLE_DEPTH_DEF][MAX_FIELDS_DEF];
	int           tbl_nf    [TABLE_DEPTH_DEF];
	int           num_entries;
	logic [7:0]   dst_chars [MAX_FIELDS_DEF][MAX_FIELD_LEN_DEF];
	int           dst_len   [MAX_FIELDS_DEF];
	parse_state_t pstate;
	int           dst_nf;
	logic [15:0]  char_sum;
	bit           overflow;

	out_beat_t    expected_results[$];
	pend_beat_t   pending_beats[$];

	int errors;
	int n_results;
	int n_matched;
	int n_status[4];
	int n_accepted;

	function automatic bit is_dest_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
		       (c >= "a" && c <= "z") || c == CH_STAR;
	endfunction

	function automatic void open_dest_field();
		if (overflow)
			return;
		if (dst_nf < MAX_FIELDS_DEF) begin
			dst_len[dst_nf] = 0;
			dst_nf++;
		end else begin
			overflow = 1'b1;
		end
	endfunction

	function automatic void collect_char(logic [7:0] c);
		int len;
		if (c >= "a" && c <= "z")
			c = c - 8'd32;
		char_sum = char_sum + 16'(c);
		if (overflow || dst_nf == 0)
			return;
		len = dst_len[dst_nf-1];
		if (len < MAX_FIELD_LEN_DEF) begin
			dst_chars[dst_nf-1][len] = c;
			dst_len[dst_nf-1] = len + 1;
		end else begin
			overflow = 1'b1;
		end
	endfunction

	// Query hits if the table is not empty and it is a trailing run of an entry's fields, or a lone asterisk.
	function automatic bit dest_in_table();
		bit ok;
		int en;
		if (num_entries == 0)
			return 1'b0;
		if (dst_nf == 1 && dst_len[0] == 1 && dst_chars[0][0] == CH_STAR)
			return 1'b1;
		for (int e = 0; e < num_entries; e++) begin
			en = tbl_nf[e];
			if (dst_nf > en)
				continue;
			ok = 1'b1;
			for (int i = 1; i <= dst_nf && ok; i++) begin
				if (tbl_len[e][en-i] != dst_len[dst_nf-i])
					ok = 1'b0;
				else
					for (int k = 0; k < dst_len[dst_nf-i]; k++)
						if (tbl_chars[e][en-i][k] != dst_chars[dst_nf-i][k])
							ok = 1'b0;
			end
			if (ok)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the shadow parser by one accepted beat; queue a result at end of string.
	function automatic void parse_dest_beat(in_beat_t b);
		out_beat_t r;
		if (b.operation == OP_CLEAR) begin
			num_entries = 0;
			return;
		end
		if (b.operation == OP_SPARE)
			return;
		case (pstate)
			PS_SKIP: begin
				if (b.character == CH_AT)
					pstate = PS_START;
				else if (b.character != CH_SPACE && b.character != CH_COMMA)
					pstate = PS_NOAT;
			end
			PS_START: begin
				if (b.character == CH_DOT || is_dest_char(b.character)) begin
					open_dest_field();
					if (b.character != CH_DOT)
						collect_char(b.character);
					pstate = PS_FIELD;
				end else begin
					pstate = PS_DONE;
				end
			end
			PS_FIELD: begin
				if (is_dest_char(b.character))
					collect_char(b.character);
				else if (b.character == CH_DOT)
					open_dest_field();
				else
					pstate = PS_DONE;
			end
			default: ;
		endcase
		if (!b.end_of_string)
			return;
		r = '0;
		if (pstate == PS_SKIP || pstate == PS_NOAT) begin
			r.status = ST_NOAT;
		end else begin
			r.field_total = 4'(dst_nf);
			r.check_word  = 16'({char_sum, 4'h0} + 20'(dst_nf & 4'hf));
			if (overflow) begin
				r.status = ST_LONG;
			end else if (b.operation == OP_QUERY) begin
				r.matched = dest_in_table();
			end else if (num_entries >= TABLE_DEPTH_DEF) begin
				r.status = ST_FULL;
			end else begin
				tbl_chars[num_entries] = dst_chars;
				for (int f = 0; f < MAX_FIELDS_DEF; f++)
					tbl_len[num_entries][f] = dst_len[f];
				tbl_nf[num_entries] = dst_nf;
				num_entries++;
			end
		end
		expected_results.insert(expected_results.size(), r);
		pstate   = PS_SKIP;
		dst_nf   = 0;
		char_sum = '0;
		overflow = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building.
	// ------------------------------------------------------------------
	bit    burst_mode;
	bit    drain_next;
	string store_pool[$];

	function automatic void push_beat(logic [1:0] op, logic [7:0] c, logic eos);
		pend_beat_t p;
		p.beat.operation     = op;
		p.beat.character     = c;
		p.beat.end_of_string = eos;
		p.gap   = burst_mode ? 0 : $urandom_range(0, 8);
		p.drain = drain_next;
		drain_next = 1'b0;
		if (($urandom_range(0, 49)) == 0)
			burst_mode = !burst_mode;
		pending_beats.insert(pending_beats.size(), p);
	endfunction

	// Send a string; the last character carries the string's operation.
	function automatic void send_string(string s, logic [1:0] op, bit mess);
		logic [7:0] c;
		logic [1:0] o;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mess && c >= "A" && c <= "Z" && $urandom_range(0, 2) == 0)
				c = c + 8'd32;
			o = op;
			if (mess && i != s.len() - 1 && $urandom_range(0, 9) == 0)
				o = (op == OP_QUERY) ? OP_STORE : OP_QUERY;
			push_beat(o, c, i == s.len() - 1);
			if (mess && i != s.len() - 1 && $urandom_range(0, 39) == 0)
				push_beat($urandom_range(0, 1) ? OP_CLEAR : OP_SPARE,
				          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endfunction

	function automatic string random_dest();
		string s;
		string vocab;
		int nf, fl;
		bit wide;
		vocab = "AB1*Z9";
		s = "";
		for (int i = $urandom_range(0, 3); i > 0; i--)
			s = $sformatf("%s%s", s, $urandom_range(0, 1) ? " " : ",");
		s = {s, "@"};
		wide = ($urandom_range(0, 9) == 0);
		nf = wide ? $urandom_range(0, 10) : $urandom_range(0, 4);
		for (int f = 0; f < nf; f++) begin
			if (f != 0)
				s = {s, "."};
			fl = wide ? $urandom_range(0, 10) : $urandom_range(0, 3);
			for (int k = 0; k < fl; k++)
				s = $sformatf("%s%c", s, vocab[$urandom_range(0, 5)]);
		end
		if ($urandom_range(0, 4) == 0)
			s = $sformatf("%s%c%c", s, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		return s;
	endfunction

	// Trailing part of a stored destination, cut at a random dot, or the whole string.
	function automatic string suffix_of(string s);
		int cuts[$];
		int at;
		at = -1;
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == CH_AT && at < 0)
				at = i;
			if (s[i] == CH_DOT && at >= 0)
				cuts.insert(cuts.size(), i);
		end
		if (at < 0 || cuts.size() == 0 || $urandom_range(0, 3) == 0)
			return s;
		return {"@", s.substr(cuts[$urandom_range(0, cuts.size() - 1)] + 1, s.len() - 1)};
	endfunction

	// ------------------------------------------------------------------
	// Driver: present one beat at a time, hold it while busy.
	// ------------------------------------------------------------------
	int waited;
	int settle;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				parse_dest_beat(cmd);
				n_accepted++;
			end
			if (start && busy) begin
				// hold the beat until it is taken
			end else if (pending_beats.size() == 0) begin
				start <= 1'b0;
			end else if (pending_beats[0].drain &&
			             (expected_results.size() != 0 || settle < HOLD_CYCLES)) begin
				start  <= 1'b0;
				settle = (expected_results.size() != 0) ? 0 : settle + 1;
			end else if (waited < pending_beats[0].gap) begin
				start  <= 1'b0;
				waited++;
			end else begin
				cmd    <= pending_beats[0].beat;
				start  <= 1'b1;
				void'(pending_beats.pop_front());
				waited = 0;
				settle = 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each strobed result with the oldest expectation.
	// ------------------------------------------------------------------
	function automatic void report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d expected %0d", what, got, want);
		errors++;
	endfunction

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && strobe) begin
			n_results++;
			n_status[result.status]++;
			if (result.matched)
				n_matched++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result status", result.status, -1);
			end else begin
				want = expected_results.pop_front();
				if (result.status != want.status)
					report_mismatch("status", result.status, want.status);
				if (result.matched != want.matched)
					report_mismatch("matched", result.matched, want.matched);
				if (result.field_total != want.field_total)
					report_mismatch("field_total", result.field_total, want.field_total);
				if (result.check_word != want.check_word)
					report_mismatch("check_word", result.check_word, want.check_word);
			end
		end
	end

	// Watchdog.
	int cycle_count;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL hier_dest_parse_match");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed strings, random strings, drain, verdict.
	// ------------------------------------------------------------------
	initial begin
		string s;
		int r;
		start       = 1'b0;
		cmd         = '0;
		arst_n      = 1'b0;
		errors      = 0;
		n_results   = 0;
		n_matched   = 0;
		n_status    = '{default: 0};
		n_accepted  = 0;
		cycle_count = 0;
		waited      = 0;
		settle      = 0;
		num_entries = 0;
		dst_len     = '{default: 0};
		dst_nf      = 0;
		char_sum    = '0;
		overflow    = 1'b0;
		pstate      = PS_SKIP;
		burst_mode  = 1'b1;
		drain_next  = 1'b0;

		// Directed: empty table, bare at-sign, no at-sign, separators, lowercase,
		// equality, suffix, lone asterisk, empty fields, too many and too long.
		send_string("@*", OP_QUERY, 0);
		send_string("@", OP_QUERY, 0);
		send_string("X", OP_QUERY, 0);
		send_string(" ,@ab.c", OP_STORE, 0);
		send_string("@AB.C", OP_QUERY, 0);
		send_string("@c", OP_QUERY, 0);
		send_string("@ab", OP_QUERY, 0);
		send_string("@*", OP_QUERY, 0);
		send_string("@", OP_QUERY, 0);
		send_string("@..", OP_STORE, 0);
		send_string("@.", OP_QUERY, 0);
		send_string("@a.b.c.d.e.f.g.h.i", OP_QUERY, 0);
		send_string("@abcdefghi", OP_STORE, 0);
		send_string("@Zz9*?junk", OP_STORE, 0);
		push_beat(OP_QUERY, 8'hff, 1'b0);
		push_beat(OP_QUERY, 8'h00, 1'b1);
		push_beat(OP_SPARE, 8'h55, 1'b1);
		push_beat(OP_CLEAR, 8'haa, 1'b0);
		send_string("@c", OP_QUERY, 0);
		drain_next = 1'b1;
		send_string("@*", OP_QUERY, 0);

		// Random: mostly well-formed strings with shared fields, some noise.
		burst_mode = 1'b0;
		while (pending_beats.size() < NUM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 38) begin
				s = random_dest();
				store_pool.insert(store_pool.size(), s);
				if (store_pool.size() > 40)
					void'(store_pool.pop_front());
				send_string(s, OP_STORE, 1);
			end else if (r < 75) begin
				if (store_pool.size() != 0 && $urandom_range(0, 3) != 0)
					s = suffix_of(store_pool[$urandom_range(0, store_pool.size() - 1)]);
				else
					s = random_dest();
				send_string(s, OP_QUERY, 1);
			end else if (r < 80) begin
				send_string("@*", OP_QUERY, 1);
			end else if (r < 91) begin
				for (int i = $urandom_range(1, 6); i > 0; i--)
					push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					          1'($urandom_range(0, 1)));
			end else if (r < 94) begin
				push_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (r < 96) begin
				drain_next = 1'b1;
			end else begin
				// close any string left open by noise
				push_beat(OP_QUERY, CH_AT, 1'b1);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_beats.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results left waiting", expected_results.size(), 0);

		$display("covered %0d beats, %0d results, %0d matched", n_accepted, n_results,
		         n_matched);
		$display("status mix: ok %0d, no at-sign %0d, too long %0d, table full %0d",
		         n_status[ST_OK], n_status[ST_NOAT], n_status[ST_LONG], n_status[ST_FULL]);
		if (errors == 0)
			$display("PASS hier_dest_parse_match");
		else
			$display("FAIL hier_dest_parse_match");
		$finish;
	end

endmodule
